FILE: rtl/sha256md_pkg.sv
// Shared types, round constants and hash functions for the SHA-256 digest core.
`default_nettype none

package sha256md_pkg;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FINAL = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_PAD2  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Where the controller goes once a compression has finished.
    typedef enum logic [1:0] {
        POST_IDLE = 2'd0,
        POST_PAD  = 2'd1,
        POST_PAD2 = 2'd2,
        POST_OUT  = 2'd3
    } post_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       absorb;       // write the input byte and count it
        logic       load_vars;    // copy the chain value into the working variables
        logic       round_en;     // run one compression round
        logic [5:0] round_idx;    // round number for the constant table
        logic       final_add;    // add the working variables into the chain value
        logic       pad_first;    // 0x80 byte, zero fill and, if it fits, the length
        logic       pad_second;   // all-zero block carrying only the length
        logic       out_shift;    // advance the digest words by one
        logic [2:0] out_idx;      // index of the initial hash word shifted in
        logic       clear_count;  // restart the byte count for the next message
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_wrap;     // the current block holds 63 bytes
        logic pad_overflow;  // the length no longer fits in the current block
    } stat_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Initial hash value.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    // Message schedule sigma functions.
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Compression round sigma functions.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256md_ctrl.sv
// Controller state machine that sequences absorption, padding, rounds and digest output.
`default_nettype none

module sha256md_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [0:0]           s_tuser,   // [0] has_byte
    input  wire logic                 s_tlast,   // end_of_message
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2:0]                m_tuser,   // [2:0] word_index
    output logic                      m_tlast,   // digest_last
    output sha256md_pkg::cmd_t        cmd,
    input  wire sha256md_pkg::stat_t  stat
);

    sha256md_pkg::state_t state_reg, state_next;
    sha256md_pkg::post_t  post_reg, post_next;
    logic [5:0]           rnd_reg, rnd_next;
    logic [2:0]           oidx_reg, oidx_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        post_next  = post_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            sha256md_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.absorb = s_tuser[0];
                    if (s_tuser[0] && stat.fill_wrap) begin
                        // The block fills up with this byte.
                        cmd.load_vars = 1'b1;
                        state_next    = sha256md_pkg::ST_ROUND;
                        post_next     = s_tlast ? sha256md_pkg::POST_PAD
                                                : sha256md_pkg::POST_IDLE;
                    end else if (s_tlast) begin
                        state_next = sha256md_pkg::ST_PAD;
                    end
                end
            end
            sha256md_pkg::ST_PAD: begin
                cmd.pad_first = 1'b1;
                cmd.load_vars = 1'b1;
                state_next    = sha256md_pkg::ST_ROUND;
                post_next     = stat.pad_overflow ? sha256md_pkg::POST_PAD2
                                                  : sha256md_pkg::POST_OUT;
            end
            sha256md_pkg::ST_PAD2: begin
                cmd.pad_second = 1'b1;
                cmd.load_vars  = 1'b1;
                state_next     = sha256md_pkg::ST_ROUND;
                post_next      = sha256md_pkg::POST_OUT;
            end
            sha256md_pkg::ST_ROUND: begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = rnd_reg;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = sha256md_pkg::ST_FINAL;
                end
            end
            sha256md_pkg::ST_FINAL: begin
                cmd.final_add = 1'b1;
                case (post_reg)
                    sha256md_pkg::POST_IDLE: state_next = sha256md_pkg::ST_IDLE;
                    sha256md_pkg::POST_PAD:  state_next = sha256md_pkg::ST_PAD;
                    sha256md_pkg::POST_PAD2: state_next = sha256md_pkg::ST_PAD2;
                    sha256md_pkg::POST_OUT:  state_next = sha256md_pkg::ST_OUT;
                    default:                 state_next = sha256md_pkg::ST_IDLE;
                endcase
            end
            sha256md_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.out_shift = 1'b1;
                    cmd.out_idx   = oidx_reg;
                    oidx_next     = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        cmd.clear_count = 1'b1;
                        state_next      = sha256md_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sha256md_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tuser = oidx_reg;
    assign m_tlast = (oidx_reg == 3'd7);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256md_pkg::ST_IDLE;
            post_reg  <= sha256md_pkg::POST_IDLE;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            post_reg  <= post_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sha256md_dp.sv
// Datapath: block buffer and message schedule, round logic, chain value and byte count.
`default_nettype none

module sha256md_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
    output logic [31:0]              m_tdata,   // [31:0] digest_word
    input  wire sha256md_pkg::cmd_t  cmd,
    output sha256md_pkg::stat_t      stat
);

    logic [31:0] blk_reg   [16];
    logic [31:0] blk_next  [16];
    logic [31:0] vars_reg  [8];
    logic [31:0] chain_reg [8];
    logic [60:0] count_reg;

    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [4:0]  bshift;
    logic [63:0] bit_len;
    logic [7:0]  merge_byte;
    logic [31:0] merged_word;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;

    // Fill position within the block follows the low bits of the byte count.
    assign pos     = count_reg[5:0];
    assign widx    = pos[5:2];
    assign bshift  = {~pos[1:0], 3'b000};
    assign bit_len = {count_reg, 3'b000};

    assign stat.fill_wrap    = (pos == 6'd63);
    assign stat.pad_overflow = (pos[5:3] == 3'd7);

    // Byte merge: the first byte of a word overwrites it, later ones are ORed in.
    assign merge_byte  = cmd.pad_first ? sha256md_pkg::PAD_BYTE : s_tdata;
    assign merged_word = ((pos[1:0] == 2'd0) ? 32'h0 : blk_reg[widx])
                         | (32'(merge_byte) << bshift);

    // Next schedule word from the sliding 16-word window.
    assign sched_new = blk_reg[0] + sha256md_pkg::small_sigma0(blk_reg[1])
                       + blk_reg[9] + sha256md_pkg::small_sigma1(blk_reg[14]);

    // Round function.
    assign ch_val  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign maj_val = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                     ^ (vars_reg[1] & vars_reg[2]);
    assign t1 = vars_reg[7] + sha256md_pkg::big_sigma1(vars_reg[4]) + ch_val
                + sha256md_pkg::round_k(cmd.round_idx) + blk_reg[0];
    assign t2 = sha256md_pkg::big_sigma0(vars_reg[0]) + maj_val;

    // Block buffer update: byte write, padding, or schedule shift.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            blk_next[i] = blk_reg[i];
            if (cmd.absorb && (4'(i) == widx)) begin
                blk_next[i] = merged_word;
            end else if (cmd.pad_first) begin
                if (4'(i) == widx) begin
                    blk_next[i] = merged_word;
                end else if (4'(i) > widx) begin
                    if (!stat.pad_overflow && i == 14) begin
                        blk_next[i] = bit_len[63:32];
                    end else if (!stat.pad_overflow && i == 15) begin
                        blk_next[i] = bit_len[31:0];
                    end else begin
                        blk_next[i] = 32'h0;
                    end
                end
            end else if (cmd.pad_second) begin
                if (i == 14) begin
                    blk_next[i] = bit_len[63:32];
                end else if (i == 15) begin
                    blk_next[i] = bit_len[31:0];
                end else begin
                    blk_next[i] = 32'h0;
                end
            end else if (cmd.round_en) begin
                blk_next[i] = (i == 15) ? sched_new : blk_reg[(i + 1) % 16];
            end
        end
    end

    // Block buffer and working variables carry no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            blk_reg[i] <= blk_next[i];
        end
        if (cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                vars_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round_en) begin
            vars_reg[0] <= t1 + t2;
            vars_reg[1] <= vars_reg[0];
            vars_reg[2] <= vars_reg[1];
            vars_reg[3] <= vars_reg[2];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[5] <= vars_reg[4];
            vars_reg[6] <= vars_reg[5];
            vars_reg[7] <= vars_reg[6];
        end
    end

    // Chain value and byte count; digest words leave through chain word zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sha256md_pkg::init_hash(3'(i));
            end
            count_reg <= '0;
        end else begin
            if (cmd.final_add) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
            end else if (cmd.out_shift) begin
                // Shift the initial hash in behind the outgoing words.
                for (int i = 0; i < 7; i++) begin
                    chain_reg[i] <= chain_reg[i + 1];
                end
                chain_reg[7] <= sha256md_pkg::init_hash(cmd.out_idx);
            end
            if (cmd.clear_count) begin
                count_reg <= '0;
            end else if (cmd.absorb) begin
                count_reg <= count_reg + 61'd1;
            end
        end
    end

    assign m_tdata = chain_reg[0];

endmodule

`default_nettype wire

FILE: rtl/sha256_message_digest_core.sv
// Top level of the SHA-256 digest core: byte stream in, eight digest words out.
// Throughput: one byte beat per cycle while a block fills. The beat that fills a block
// is followed by a compression (64 rounds, one per cycle, plus the chain add), and the
// input stays stalled until it ends. A message end adds a padding step before each of
// one or two compressions, then 8 digest beats, one per cycle at best.
// Reset (aresetn low, synchronous) loads the initial hash and clears the byte count.
`default_nettype none

module sha256_message_digest_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast    // digest_last
);

    sha256md_pkg::cmd_t  cmd;
    sha256md_pkg::stat_t stat;

    // Sequencer.
    sha256md_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Hash datapath.
    sha256md_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The input side and the digest side are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input accepted while digest words are pending");

    // A message end leads to padding, after a compression if its byte fills the block, so the input closes next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after end of message");

    // Digest words come out with consecutive indexes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1))))
        else $error("digest word index out of sequence");

    // After the last digest beat the core takes the next message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("core not idle after the last digest word");

endmodule

`default_nettype wire
